@@ rtl/assert_macros.svh @@
// Assertion helpers for the DMX512 receiver.
// Each macro samples on the rising edge of clk and stays quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/dmxr_pkg.sv @@
`default_nettype none

package dmxr_pkg;

    // Fixed geometry of the channel store and the slot counter.
    localparam int STORE_DEPTH = 512;
    localparam int ADDR_W      = 9;
    localparam int INDEX_W     = 10;
    localparam int BYTE_W      = 8;

    // Receiver states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BREAK = 2'd1,
        ST_DATA  = 2'd2
    } rx_state_t;

    // Kind of input word.
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_READ = 1'b1
    } op_t;

    // One input word after unpacking.
    typedef struct packed {
        op_t               op;
        logic              brk;
        logic [BYTE_W-1:0] data;
        logic [ADDR_W-1:0] rd;
    } item_t;

    // Result of one step, minus the read data that comes from the store.
    typedef struct packed {
        rx_state_t          state;
        logic [INDEX_W-1:0] slot_index;
        logic               stored;
        logic               frame_done;
        logic               read_hit;
    } result_t;

    // Write port request to the channel store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } store_wr_t;

    // Read port request to the channel store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

endpackage

`default_nettype wire

@@ rtl/dmx512_frame_receiver_unit.sv @@
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    tuser: op, break_flag; tdata: rx_byte, read_channel
// m_       out  m_tvalid/m_tready    tdata: rx_state, slot_index, stored, frame_done,
//                                    read_value
// One word is accepted per cycle while the output is not stalled; each result passes through
// the input register, then the output register with the store read data, and is presented
// from the output register.
// The state update and the store access happen as a word moves to the output register.
// Reset clears the receiver state; the store reads as zero until a frame writes it,
// tracked by a fill mark, so no clearing pass is needed.
// A stalled output holds its word while one more input word waits in the input register.
`default_nettype none

`include "assert_macros.svh"

module dmx512_frame_receiver_unit
    import dmxr_pkg::*;
#(
    parameter int CHANNELS = 512
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // [0] op, [1] break_flag
    input  wire logic [23:0] s_tdata,   // [7:0] rx_byte, [16:8] read_channel, rest zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [1:0] rx_state, [11:2] slot_index, [12] stored,
                                        // [13] frame_done, [21:14] read_value, rest zero
);

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    logic        advance;
    item_t       in_item;
    result_t     res;
    store_wr_t   wr;
    store_rd_t   rd;
    logic [BYTE_W-1:0] store_q;
    logic [BYTE_W-1:0] read_value;

    // Unpack the incoming word.
    always_comb
    begin
        in_item.op   = op_t'(s_tuser[0]);
        in_item.brk  = s_tuser[1];
        in_item.data = s_tdata[7:0];
        in_item.rd   = s_tdata[16:8];
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item;
        end
    end

    dmxr_fsm #(
        .CHANNELS (CHANNELS)
    ) u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (in_item_reg),
        .res   (res),
        .wr    (wr),
        .rd    (rd)
    );

    dmxr_store u_store (
        .clk (clk),
        .wr  (wr),
        .rd  (rd),
        .q   (store_q)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    // Slots never written since reset read as zero.
    assign read_value = out_res_reg.read_hit ? store_q : '0;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {2'b00, read_value, out_res_reg.frame_done, out_res_reg.stored,
                         out_res_reg.slot_index, out_res_reg.state};

    // A finished frame leaves the receiver idle, having just stored its last slot.
    `ASSERT_SAME(a_done_idle, m_tvalid && out_res_reg.frame_done,
                 out_res_reg.stored && (out_res_reg.state == ST_IDLE))
    // While receiving data the slot index stays inside the frame.
    `ASSERT_SAME(a_data_index, m_tvalid && (out_res_reg.state == ST_DATA),
                 out_res_reg.slot_index < INDEX_W'(CHANNELS))
    // A stored byte always advances the slot index past zero.
    `ASSERT_SAME(a_stored_index, m_tvalid && out_res_reg.stored,
                 out_res_reg.slot_index != '0)
    // A word that moves on is replaced by a valid result in the next cycle.
    `ASSERT_NEXT(a_advance_out, advance, out_valid_reg)

endmodule

`default_nettype wire

@@ rtl/dmxr_store.sv @@
`default_nettype none

module dmxr_store
    import dmxr_pkg::*;
(
    input  wire logic              clk,
    input  wire store_wr_t         wr,
    input  wire store_rd_t         rd,
    output logic [BYTE_W-1:0]      q
);

    logic [BYTE_W-1:0] mem [STORE_DEPTH];
    logic [BYTE_W-1:0] q_reg;

    // Single write port and one registered read port; a step never does both.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            q_reg <= mem[rd.addr];
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ rtl/dmxr_fsm.sv @@
`default_nettype none

module dmxr_fsm
    import dmxr_pkg::*;
#(
    parameter int CHANNELS = 512
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire item_t item,
    output result_t    res,
    output store_wr_t  wr,
    output store_rd_t  rd
);

    localparam logic [INDEX_W-1:0] LastIndex = INDEX_W'(CHANNELS);

    rx_state_t          state_reg, state_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    // Fill mark: slots below it were written since reset, the rest read as zero.
    logic [INDEX_W-1:0] fill_reg, fill_next;
    logic [INDEX_W-1:0] index_plus;
    logic               stored;
    logic               done;

    assign index_plus = index_reg + INDEX_W'(1);

    // Next state for one word.
    always_comb
    begin
        state_next = state_reg;
        index_next = index_reg;
        fill_next  = fill_reg;
        stored     = 1'b0;
        done       = 1'b0;
        if (item.op == OP_READ)
        begin
            state_next = state_reg;
        end
        else if (item.brk)
        begin
            state_next = ST_BREAK;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    state_next = ST_IDLE;
                end
                ST_BREAK:
                begin
                    if (item.data == '0)
                    begin
                        state_next = ST_DATA;
                        index_next = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_DATA:
                begin
                    if (index_reg >= LastIndex)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        stored     = 1'b1;
                        index_next = index_plus;
                        if (index_plus > fill_reg)
                        begin
                            fill_next = index_plus;
                        end
                        if (index_plus >= LastIndex)
                        begin
                            state_next = ST_IDLE;
                            done       = 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // State registers advance only when the word moves to the output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            index_reg <= '0;
            fill_reg  <= '0;
        end
        else if (en)
        begin
            state_reg <= state_next;
            index_reg <= index_next;
            fill_reg  <= fill_next;
        end
    end

    // Store requests and the step result.
    always_comb
    begin
        wr.en   = en && stored;
        wr.addr = index_reg[ADDR_W-1:0];
        wr.data = item.data;
        rd.en   = en && (item.op == OP_READ);
        rd.addr = item.rd;

        res.state      = state_next;
        res.slot_index = index_next;
        res.stored     = stored;
        res.frame_done = done;
        res.read_hit   = (item.op == OP_READ) && ({1'b0, item.rd} < fill_reg);
    end

endmodule

`default_nettype wire

@@ tb/sv/dmx512_frame_receiver_unit_test.sv @@
`default_nettype none

module dmx512_frame_receiver_unit_test;
    import dmxr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 512;
    localparam int TARGET      = 1600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS  = 40;

    // One expected result word, unpacked.
    typedef struct {
        rx_state_t          state;
        logic [INDEX_W-1:0] slot;
        logic               stored;
        logic               done;
        logic [BYTE_W-1:0]  rval;
    } dmx_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Words waiting to be driven and results waiting to arrive.
    item_t       stim_words[$];
    dmx_result_t expected_results[$];

    // Shadow copy of the receiver.
    rx_state_t          pr_state = ST_IDLE;
    logic [INDEX_W-1:0] pr_index = '0;
    logic [BYTE_W-1:0]  shadow_store [STORE_DEPTH];

    int  total_words = 0;
    int  accepted = 0;
    int  results_seen = 0;
    int  frames_done = 0;
    int  slots_stored = 0;
    int  reads_seen = 0;
    int  errors = 0;
    int  cycles = 0;
    int  hold_left = 0;
    bit  hold_used = 1'b0;
    bit  took = 1'b0;

    dmx512_frame_receiver_unit #(.CHANNELS(SLOTS)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // Prints one line per mismatch, up to a cap, and counts all of them.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < MAX_PRINTS)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
        errors++;
    endtask

    // Advances the shadow receiver by one word and returns the result it causes.
    task automatic receive_step(input item_t w, output dmx_result_t res);
        res.stored = 1'b0;
        res.done   = 1'b0;
        res.rval   = '0;
        if (w.op == OP_READ)
            res.rval = shadow_store[w.rd];
        else if (w.brk)
            pr_state = ST_BREAK;
        else
        begin
            case (pr_state)
                ST_BREAK:
                begin
                    // Only a zero start code opens a frame.
                    if (w.data == '0)
                    begin
                        pr_state = ST_DATA;
                        pr_index = '0;
                    end
                    else
                        pr_state = ST_IDLE;
                end
                ST_DATA:
                begin
                    if (pr_index >= SLOTS)
                        pr_state = ST_IDLE;
                    else
                    begin
                        shadow_store[pr_index[ADDR_W-1:0]] = w.data;
                        res.stored = 1'b1;
                        pr_index = pr_index + 1'b1;
                        if (pr_index >= SLOTS)
                        begin
                            pr_state = ST_IDLE;
                            res.done = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        res.state = pr_state;
        res.slot  = pr_index;
    endtask

    task automatic push_byte(input logic brk, input logic [BYTE_W-1:0] data);
        item_t w;
        w.op   = OP_BYTE;
        w.brk  = brk;
        w.data = data;
        w.rd   = ADDR_W'($urandom_range(STORE_DEPTH - 1));
        stim_words.push_back(w);
    endtask

    task automatic push_read(input logic [ADDR_W-1:0] ch);
        item_t w;
        w.op   = OP_READ;
        w.brk  = 1'($urandom_range(1));
        w.data = BYTE_W'($urandom);
        w.rd   = ch;
        stim_words.push_back(w);
    endtask

    // One or two breaks, a zero start code and len data bytes with reads mixed in.
    task automatic push_frame(input int len);
        int nbrk;
        nbrk = ($urandom_range(3) == 0) ? 2 : 1;
        repeat (nbrk) push_byte(1'b1, BYTE_W'($urandom));
        push_byte(1'b0, 8'h00);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                push_read($urandom_range(1) ? ADDR_W'($urandom_range(63))
                                            : ADDR_W'($urandom_range(STORE_DEPTH - 1)));
            push_byte(1'b0, BYTE_W'($urandom));
        end
    endtask

    function automatic int phase_now();
        int ph;
        ph = (total_words > 0) ? (accepted * 4) / total_words : 0;
        return (ph > 3) ? 3 : ph;
    endfunction

    // Input side: predict every accepted word.
    always @(posedge clk)
    begin
        item_t       w;
        dmx_result_t res;
        took <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            w.op   = op_t'(s_tuser[0]);
            w.brk  = s_tuser[1];
            w.data = s_tdata[7:0];
            w.rd   = s_tdata[16:8];
            receive_step(w, res);
            expected_results.push_back(res);
            accepted++;
            if (res.done)
                frames_done++;
            if (res.stored)
                slots_stored++;
            if (w.op == OP_READ)
                reads_seen++;
        end
    end

    // Output side: compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        dmx_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result word", int'(m_tdata), 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[1:0] != want.state)
                    report_mismatch("rx_state", int'(m_tdata[1:0]), int'(want.state));
                if (m_tdata[11:2] != want.slot)
                    report_mismatch("slot_index", int'(m_tdata[11:2]), int'(want.slot));
                if (m_tdata[12] != want.stored)
                    report_mismatch("stored", int'(m_tdata[12]), int'(want.stored));
                if (m_tdata[13] != want.done)
                    report_mismatch("frame_done", int'(m_tdata[13]), int'(want.done));
                if (m_tdata[21:14] != want.rval)
                    report_mismatch("read_value", int'(m_tdata[21:14]), int'(want.rval));
            end
            results_seen++;
        end
    end

    // Driver: offers the next pending word, with sender gaps in some phases.
    always @(negedge clk)
    begin
        item_t w;
        int    gap_pct;
        if (rst_n && (!s_tvalid || took))
        begin
            case (phase_now())
                1:       gap_pct = 54;
                3:       gap_pct = 31;
                default: gap_pct = 0;
            endcase
            if (stim_words.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                w = stim_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= {w.brk, w.op};
                s_tdata  <= {7'd0, w.rd, w.data};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver ready, with random stalls in some phases and the long hold-off.
    always @(negedge clk)
    begin
        int stall_pct;
        case (phase_now())
            2:       stall_pct = 54;
            3:       stall_pct = 31;
            default: stall_pct = 0;
        endcase
        if (!rst_n || hold_left != 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // One long hold-off early on, while the sender keeps offering words.
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_used && rst_n && accepted >= 150)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int len;
        bit first;

        foreach (shadow_store[i])
            shadow_store[i] = '0;

        // Directed part: reset contents, ignored bytes, breaks, start codes, reads.
        push_read(9'd0);
        push_read(9'd511);
        push_byte(1'b0, 8'hFF);
        push_byte(1'b0, 8'h00);
        push_byte(1'b1, 8'h00);
        push_byte(1'b1, 8'hFF);
        push_byte(1'b0, 8'h55);
        push_byte(1'b1, 8'hAA);
        push_byte(1'b0, 8'h00);
        push_byte(1'b0, 8'hFF);
        push_byte(1'b0, 8'h00);
        push_byte(1'b0, 8'hA5);
        push_read(9'd1);
        push_read(9'd2);
        // A break inside a frame keeps the slot index.
        push_byte(1'b1, 8'h33);
        push_byte(1'b0, 8'h12);
        push_byte(1'b1, 8'h00);
        push_byte(1'b0, 8'h00);
        push_byte(1'b0, 8'h7E);
        push_read(9'd0);
        push_read(9'd300);
        push_read(9'd256);

        // Random part: mostly frames, some full, plus bad start codes and noise.
        first = 1'b1;
        while (stim_words.size() < TARGET)
        begin
            kind = $urandom_range(99);
            if (first || kind < 70)
            begin
                if (first || $urandom_range(29) == 0)
                    len = SLOTS + $urandom_range(3);
                else
                    len = $urandom_range(1, 40);
                push_frame(len);
                first = 1'b0;
            end
            else if (kind < 80)
            begin
                push_byte(1'b1, BYTE_W'($urandom));
                push_byte(1'b0, BYTE_W'($urandom_range(1, 255)));
                repeat ($urandom_range(3)) push_byte(1'b0, BYTE_W'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(1))
                        push_read(ADDR_W'($urandom_range(STORE_DEPTH - 1)));
                    else
                        push_byte(($urandom_range(3) == 0), BYTE_W'($urandom));
                end
            end
        end
        total_words = stim_words.size();

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Drain: all words accepted, all results in, then a quiet tail.
        while (stim_words.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("drove %0d words, checked %0d results: %0d frames completed, %0d slots",
                 accepted, results_seen, frames_done, slots_stored);
        $display("stored, %0d channel reads, %0d mismatches", reads_seen, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
